// ===== rtl/fpdf_pkg.sv =====
// Shared types and constants for the fixed-point decimal formatter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fpdf_pkg;

   // ASCII codes used in the field
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // register map: index is paddr[2]
   localparam int         CFG_ADDR_W         = 3;
   localparam logic       REG_DIGIT_COUNT    = 1'b0;
   localparam logic       REG_POINT_POSITION = 1'b1;
   localparam logic [3:0] DIGIT_COUNT_RESET  = 4'd4;
   localparam logic [3:0] POINT_RESET        = 4'd3;

   // n / 10 == (n * RECIP_10) >> RECIP_SHIFT for every 32-bit n
   localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // per-item control that rides along the pipeline
   typedef struct packed {
      logic       neg;
      logic       ovf;
      logic [3:0] dig_cnt;
      logic [3:0] point;
   } fpdf_ctl_type;

   function automatic logic [31:0] pow10(input logic [3:0] k);
      logic [31:0] r;
      unique case (k)
         4'd0:    r = 32'd1;
         4'd1:    r = 32'd10;
         4'd2:    r = 32'd100;
         4'd3:    r = 32'd1000;
         4'd4:    r = 32'd10000;
         4'd5:    r = 32'd100000;
         4'd6:    r = 32'd1000000;
         4'd7:    r = 32'd10000000;
         4'd8:    r = 32'd100000000;
         4'd9:    r = 32'd1000000000;
         default: r = 32'hFFFF_FFFF;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fpdf_digit_stage.sv =====
// One pipeline stage that peels off a decimal digit: divides the running
// quotient by ten with a reciprocal multiply. Uses fpdf_pkg.
`default_nettype none

module fpdf_digit_stage
   import fpdf_pkg::*;
#(
   parameter int NDIG = 9,
   parameter int IDX  = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  logic [31:0]               up_rem,
   input  logic [NDIG-1:0][3:0]      up_digits,
   input  fpdf_ctl_type              up_ctl,
   output logic                      down_valid,
   input  logic                      down_ready,
   output logic [31:0]               down_rem,
   output logic [NDIG-1:0][3:0]      down_digits,
   output fpdf_ctl_type              down_ctl
);

   logic [63:0]          prod;
   logic [31:0]          quot;
   logic [3:0]           q10;
   logic [3:0]           digit;
   logic [NDIG-1:0][3:0] digits_in;
   logic                 valid_ff;
   logic [31:0]          rem_ff;
   logic [NDIG-1:0][3:0] digits_ff;
   fpdf_ctl_type         ctl_ff;

   assign prod = 64'(up_rem) * 64'(RECIP_10);
   assign quot = 32'(prod[63:RECIP_SHIFT]);
   // remainder is below ten, so four bits of n - 10q are enough
   assign q10   = 4'({quot[3:0], 3'b000} + {3'b000, quot[3:0], 1'b0});
   assign digit = up_rem[3:0] - q10;

   always_comb begin
      digits_in      = up_digits;
      digits_in[IDX] = digit;
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         rem_ff    <= quot;
         digits_ff <= digits_in;
         ctl_ff    <= up_ctl;
      end
   end

   assign down_valid  = valid_ff;
   assign down_rem    = rem_ff;
   assign down_digits = digits_ff;
   assign down_ctl    = ctl_ff;

endmodule

`default_nettype wire

// ===== rtl/fpdf_layout_stage.sv =====
// Pipeline stage that lays out the whole ASCII field from the decimal digits,
// sign, overflow flag and point position. Uses fpdf_pkg.
`default_nettype none

module fpdf_layout_stage
   import fpdf_pkg::*;
#(
   parameter int NDIG = 9,
   parameter int FL   = NDIG + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic [NDIG-1:0][3:0]  up_digits,
   input  fpdf_ctl_type          up_ctl,
   output logic                  down_valid,
   input  logic                  down_ready,
   output logic [FL-1:0][7:0]    down_chars,
   output logic [3:0]            down_len,
   output logic                  down_ovf
);

   logic [3:0]         sig;
   logic [3:0]         frac1;
   logic [3:0]         top;
   logic [7:0]         sign_ch;
   logic [FL-1:0][3:0] jdx;
   logic [FL-1:0][3:0] dsel;
   logic [FL-1:0][7:0] chars_in;
   logic               valid_ff;
   logic [FL-1:0][7:0] chars_ff;
   logic [3:0]         len_ff;
   logic               ovf_ff;

   // count of significant digits, zero for a zero magnitude
   always_comb begin
      sig = 4'd0;
      for (int k = 0; k < NDIG; k++) begin
         if (up_digits[k] != 4'd0) begin
            sig = 4'(k + 1);
         end
      end
   end

   // fraction digits plus the forced units digit
   assign frac1   = up_ctl.dig_cnt + 4'd2 - up_ctl.point;
   assign top     = (sig > frac1) ? sig : frac1;
   assign sign_ch = up_ctl.neg ? CH_MINUS : CH_SPACE;

   // digit index shown at each character position
   always_comb begin
      for (int i = 0; i < FL; i++) begin
         if (4'(i) > up_ctl.point) begin
            jdx[i] = up_ctl.dig_cnt + 4'd1 - 4'(i);
         end else begin
            jdx[i] = up_ctl.dig_cnt - 4'(i);
         end
         dsel[i] = 4'd0;
         for (int k = 0; k < NDIG; k++) begin
            if (4'(k) == jdx[i]) begin
               dsel[i] = up_digits[k];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < FL; i++) begin
         if (up_ctl.ovf) begin
            if (i == 0) begin
               chars_in[i] = sign_ch;
            end else if (4'(i) == up_ctl.point) begin
               chars_in[i] = CH_POINT;
            end else begin
               chars_in[i] = CH_STAR;
            end
         end else begin
            if (4'(i) == up_ctl.point) begin
               chars_in[i] = CH_POINT;
            end else if (jdx[i] < top) begin
               chars_in[i] = CH_ZERO + {4'b0000, dsel[i]};
            end else if (jdx[i] == top) begin
               chars_in[i] = sign_ch;
            end else begin
               chars_in[i] = CH_SPACE;
            end
         end
      end
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         chars_ff <= chars_in;
         len_ff   <= up_ctl.dig_cnt + 4'd2;
         ovf_ff   <= up_ctl.ovf;
      end
   end

   assign down_valid = valid_ff;
   assign down_chars = chars_ff;
   assign down_len   = len_ff;
   assign down_ovf   = ovf_ff;

endmodule

`default_nettype wire

// ===== rtl/fpdf_serializer.sv =====
// Holds a laid-out field, sends it via an output register one character per
// cycle while rsp_ready is high; takes next field as the last char goes out.
`default_nettype none

module fpdf_serializer
   import fpdf_pkg::*;
#(
   parameter int FL = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  logic [FL-1:0][7:0] up_chars,
   input  logic [3:0]         up_len,
   input  logic               up_ovf,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_character,
   output logic [3:0]         rsp_position,
   output logic               rsp_overflow,
   output logic               rsp_last
);

   localparam int IDX_W = $clog2(FL);

   logic               busy_ff;
   logic               busy_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;
   logic [FL-1:0][7:0] field_ff;
   logic [3:0]         len_ff;
   logic               ovf_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [7:0]         char_ff;
   logic [3:0]         pos_ff;
   logic               oflag_ff;
   logic               last_ff;
   logic               load_out;
   logic               last_now;
   logic               take;

   assign last_now = (4'(idx_ff) == len_ff - 4'd1);
   assign load_out = busy_ff && (!out_valid_ff || rsp_ready);
   assign up_ready = !busy_ff || (load_out && last_now);
   assign take     = up_valid && up_ready;

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (take) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (load_out) begin
         idx_in = idx_ff + 1'b1;
         if (last_now) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         field_ff <= up_chars;
         len_ff   <= up_len;
         ovf_ff   <= up_ovf;
      end
      if (load_out) begin
         char_ff  <= field_ff[idx_ff];
         pos_ff   <= 4'(idx_ff);
         oflag_ff <= ovf_ff;
         last_ff  <= last_now;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_position  = pos_ff;
   assign rsp_overflow  = oflag_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

// ===== rtl/fixed_point_decimal_formatter_core.sv =====
// Top level of the fixed-point decimal formatter: config registers, sign and
// range front end, digit pipeline, layout stage and serializer. Uses fpdf_pkg.
//
// Each signed 32-bit value becomes a field of digit_count+2 ASCII characters,
// sent left to right, one character per cycle while rsp_ready is high, each
// with its position, the overflow flag and a last marker. The output channel
// sets the rate; the serializer takes the next field as the last character of
// the previous one enters the output register, so fields follow each other
// without gaps. Sign and magnitude are registered at the accepting edge; the
// value then passes the range check, one divide-by-ten stage per digit, the
// layout stage, the field buffer and the output register before its first
// character is valid. Out-of-range register values are clamped: digit_count
// to 1..MAX_DIGITS, point_position to 2..digit_count+1. The user must write
// the registers over the APB port only while no value is in flight; the
// block itself does not enforce this.
`default_nettype none

module fixed_point_decimal_formatter_core
   import fpdf_pkg::*;
#(
   parameter int MAX_DIGITS = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [31:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_character,
   output logic [3:0]            rsp_position,
   output logic                  rsp_overflow,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CFG_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int FL = MAX_DIGITS + 2;

   // configuration
   logic [3:0] dig_cnt_ff;
   logic [3:0] point_ff;
   logic [3:0] dig_eff;
   logic [3:0] point_eff;
   logic       cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dig_cnt_ff <= DIGIT_COUNT_RESET;
         point_ff   <= POINT_RESET;
      end else if (cfg_write) begin
         unique case (paddr[2])
            REG_DIGIT_COUNT:    dig_cnt_ff <= pwdata[3:0];
            REG_POINT_POSITION: point_ff   <= pwdata[3:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_DIGIT_COUNT:    prdata = {28'd0, dig_cnt_ff};
         REG_POINT_POSITION: prdata = {28'd0, point_ff};
         default:            prdata = 32'd0;
      endcase
   end

   always_comb begin
      if (dig_cnt_ff == 4'd0) begin
         dig_eff = 4'd1;
      end else if (dig_cnt_ff > 4'(MAX_DIGITS)) begin
         dig_eff = 4'(MAX_DIGITS);
      end else begin
         dig_eff = dig_cnt_ff;
      end
      if (point_ff < 4'd2) begin
         point_eff = 4'd2;
      end else if (point_ff > dig_eff + 4'd1) begin
         point_eff = dig_eff + 4'd1;
      end else begin
         point_eff = point_ff;
      end
   end

   // stage A: sign and magnitude
   logic         a_valid_ff;
   logic         a_ready;
   logic [31:0]  a_mag_ff;
   fpdf_ctl_type a_ctl_ff;
   logic [31:0]  mag_in;
   fpdf_ctl_type a_ctl_in;

   assign mag_in = req_value[31] ? (32'd0 - 32'(req_value)) : 32'(req_value);

   always_comb begin
      a_ctl_in         = '0;
      a_ctl_in.neg     = req_value[31];
      a_ctl_in.dig_cnt = dig_eff;
      a_ctl_in.point   = point_eff;
   end

   // stage B: range check
   logic         b_valid_ff;
   logic         b_ready;
   logic [31:0]  b_mag_ff;
   fpdf_ctl_type b_ctl_ff;
   fpdf_ctl_type b_ctl_in;

   always_comb begin
      b_ctl_in     = a_ctl_ff;
      b_ctl_in.ovf = (a_mag_ff >= pow10(a_ctl_ff.dig_cnt));
   end

   // digit pipeline
   logic [MAX_DIGITS:0]           st_valid;
   logic [MAX_DIGITS:0]           st_ready;
   logic [31:0]                   st_rem    [0:MAX_DIGITS];
   logic [MAX_DIGITS-1:0][3:0]    st_digits [0:MAX_DIGITS];
   fpdf_ctl_type                  st_ctl    [0:MAX_DIGITS];

   assign req_ready = !a_valid_ff || b_ready;
   assign a_ready   = req_ready;
   assign b_ready   = !b_valid_ff || st_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= req_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && req_valid) begin
         a_mag_ff <= mag_in;
         a_ctl_ff <= a_ctl_in;
      end
      if (b_ready && a_valid_ff) begin
         b_mag_ff <= a_mag_ff;
         b_ctl_ff <= b_ctl_in;
      end
   end

   assign st_valid[0]  = b_valid_ff;
   assign st_rem[0]    = b_mag_ff;
   assign st_digits[0] = '0;
   assign st_ctl[0]    = b_ctl_ff;

   for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_digit
      fpdf_digit_stage #(
         .NDIG (MAX_DIGITS),
         .IDX  (g)
      ) u_digit (
         .clock       (clock),
         .reset       (reset),
         .up_valid    (st_valid[g]),
         .up_ready    (st_ready[g]),
         .up_rem      (st_rem[g]),
         .up_digits   (st_digits[g]),
         .up_ctl      (st_ctl[g]),
         .down_valid  (st_valid[g+1]),
         .down_ready  (st_ready[g+1]),
         .down_rem    (st_rem[g+1]),
         .down_digits (st_digits[g+1]),
         .down_ctl    (st_ctl[g+1])
      );
   end

   // layout and serializer
   logic               lay_valid;
   logic               lay_ready;
   logic [FL-1:0][7:0] lay_chars;
   logic [3:0]         lay_len;
   logic               lay_ovf;

   fpdf_layout_stage #(
      .NDIG (MAX_DIGITS),
      .FL   (FL)
   ) u_layout (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (st_valid[MAX_DIGITS]),
      .up_ready   (st_ready[MAX_DIGITS]),
      .up_digits  (st_digits[MAX_DIGITS]),
      .up_ctl     (st_ctl[MAX_DIGITS]),
      .down_valid (lay_valid),
      .down_ready (lay_ready),
      .down_chars (lay_chars),
      .down_len   (lay_len),
      .down_ovf   (lay_ovf)
   );

   fpdf_serializer #(
      .FL (FL)
   ) u_serializer (
      .clock         (clock),
      .reset         (reset),
      .up_valid      (lay_valid),
      .up_ready      (lay_ready),
      .up_chars      (lay_chars),
      .up_len        (lay_len),
      .up_ovf        (lay_ovf),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_position  (rsp_position),
      .rsp_overflow  (rsp_overflow),
      .rsp_last      (rsp_last)
   );

   // a value in range leaves no quotient after all digit stages
   a_digits_exhausted: assert property (@(posedge clock) disable iff (reset)
      st_valid[MAX_DIGITS] && !st_ctl[MAX_DIGITS].ovf |-> st_rem[MAX_DIGITS] == 32'd0)
      else $error("digit pipeline left a nonzero quotient");

   // characters of one field go out back to back in order
   a_next_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && (rsp_position == $past(rsp_position) + 4'd1))
      else $error("field character missing or out of order");

   // field length follows the clamped digit count
   a_field_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_position == dig_eff + 4'd1)
      else $error("last character at wrong position");

endmodule

`default_nettype wire

// ===== tb/sv/fixed_point_decimal_formatter_core_tb.sv =====
// Self-checking testbench for fixed_point_decimal_formatter_core: drives values and APB
// register writes, predicts each ASCII field and checks every character in order.
// Depends on fpdf_pkg and the core RTL only.
`default_nettype none

module fixed_point_decimal_formatter_core_tb
   import fpdf_pkg::*;
();

   localparam int MAX_DIGITS   = 9;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 30;   // more than the first-char latency plus a full field
   localparam int SEGMENTS     = 12;
   localparam int SEG_ITEMS    = 17;

   localparam logic [31:0] CORNER_VALUES [12] = '{
      32'd0, 32'd1, -32'd1, 32'd9999, 32'd10000, -32'd9999, -32'd10000,
      32'd5, 32'd123, 32'h7FFF_FFFF, 32'h8000_0000, 32'd999999999
   };

   typedef struct packed {
      logic [7:0] character;
      logic [3:0] position;
      logic       overflow;
      logic       last;
   } fmt_char_type;

   class fpdf_field_checker;
      logic [3:0]   digit_count;
      logic [3:0]   point_position;
      fmt_char_type expected_chars[$];
      int           mismatches;

      function new();
         digit_count    = DIGIT_COUNT_RESET;
         point_position = POINT_RESET;
         mismatches     = 0;
      endfunction

      function int shown_digits();
         int d;
         d = int'(digit_count);
         if (d < 1) d = 1;
         if (d > MAX_DIGITS) d = MAX_DIGITS;
         return d;
      endfunction

      // smallest magnitude that no longer fits
      function logic [31:0] field_limit();
         logic [31:0] lim;
         int          i;
         lim = 32'd1;
         for (i = 0; i < shown_digits(); i++) lim = lim * 10;
         return lim;
      endfunction

      function void flag(string msg);
         if (mismatches < 10) $display("%s", msg);
         mismatches++;
      endfunction

      function void note_value(logic [31:0] value);
         logic [7:0]   field [0:MAX_DIGITS+1];
         logic [31:0]  mag;
         logic [31:0]  lim;
         logic         neg;
         logic         ovf;
         int           d, p, len, spot, i;
         fmt_char_type c;
         neg = value[31];
         mag = neg ? 32'd0 - value : value;
         d   = shown_digits();
         p   = int'(point_position);
         if (p < 2) p = 2;
         if (p > d + 1) p = d + 1;
         len = d + 2;
         lim = field_limit();
         ovf = (mag >= lim);
         for (i = 0; i <= MAX_DIGITS + 1; i++) field[i] = CH_SPACE;
         if (!ovf) begin
            for (i = len - 1; i > p; i--) begin
               field[i] = CH_ZERO + 8'(mag % 10);
               mag      = mag / 10;
            end
            field[p] = CH_POINT;
            spot     = p;
            if (mag == 0) begin
               spot--;
               field[spot] = CH_ZERO;
            end else begin
               while (mag != 0 && spot > 1) begin
                  spot--;
                  field[spot] = CH_ZERO + 8'(mag % 10);
                  mag         = mag / 10;
               end
            end
            field[spot-1] = neg ? CH_MINUS : CH_SPACE;
         end else begin
            field[0] = neg ? CH_MINUS : CH_SPACE;
            for (i = 1; i < len; i++) field[i] = (i == p) ? CH_POINT : CH_STAR;
         end
         for (i = 0; i < len; i++) begin
            c.character = field[i];
            c.position  = 4'(i);
            c.overflow  = ovf;
            c.last      = (i == len - 1);
            expected_chars.push_back(c);
         end
      endfunction

      function void check_char(logic [7:0] ch, logic [3:0] pos, logic ovf, logic lst);
         fmt_char_type want;
         if (expected_chars.size() == 0) begin
            flag($sformatf("unexpected item: char %h pos %0d ovf %b last %b",
                           ch, pos, ovf, lst));
            return;
         end
         want = expected_chars.pop_front();
         if (ch !== want.character || pos !== want.position ||
             ovf !== want.overflow || lst !== want.last)
            flag($sformatf({"mismatch: expected char %h pos %0d ovf %b last %b, ",
                            "got char %h pos %0d ovf %b last %b"},
                           want.character, want.position, want.overflow, want.last,
                           ch, pos, ovf, lst));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic signed [31:0]    req_value;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_character;
   logic [3:0]            rsp_position;
   logic                  rsp_overflow;
   logic                  rsp_last;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CFG_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   int unsigned       send_idle_pct = 6;
   int unsigned       recv_idle_pct = 58;
   int                stall_cycles;
   fpdf_field_checker sb;

   fixed_point_decimal_formatter_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_position  (rsp_position),
      .rsp_overflow  (rsp_overflow),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_char(rsp_character, rsp_position, rsp_overflow, rsp_last);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("fixed_point_decimal_formatter_core_tb failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_value(input logic [31:0] v);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_value = v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_value(v);
   endtask

   // drop valid and hold off until every queued character has come out
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_chars.size() != 0) @(negedge clock);
   endtask

   task automatic apb_write(input logic idx, input logic [3:0] val);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = {28'($urandom()), val};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == REG_DIGIT_COUNT) sb.digit_count = val;
      else sb.point_position = val;
      @(negedge clock);
      // register reads back the low four bits that were written, zero above
      if (prdata !== {28'd0, val})
         sb.flag($sformatf("register %0d readback: expected %h, got %h",
                           idx, {28'd0, val}, prdata));
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic configure(input logic [3:0] dc, input logic [3:0] pp);
      wait_drained();
      apb_write(REG_DIGIT_COUNT, dc);
      apb_write(REG_POINT_POSITION, pp);
   endtask

   // mostly in-range magnitudes for the current width, plus edges and overflow
   function automatic logic [31:0] pick_value();
      logic [31:0] lim;
      logic [31:0] mag;
      lim = sb.field_limit();
      case ($urandom_range(0, 9))
         0, 1:       return $urandom();
         2, 3, 4, 5: mag = $urandom() % lim;
         6:          mag = lim - 1 + $urandom_range(0, 2);
         7:          mag = $urandom_range(0, 99);
         8:          mag = $urandom_range(32'h7FFF_FFFF, lim);
         default:    mag = $urandom_range(0, 1) ? 32'h8000_0000 : 32'd0;
      endcase
      return $urandom_range(0, 1) ? 32'd0 - mag : mag;
   endfunction

   initial begin
      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corners at the reset format
      foreach (CORNER_VALUES[i]) send_value(CORNER_VALUES[i]);

      configure(4'd9, 4'd10);
      send_value(32'd999999999);
      send_value(32'd1000000000);
      send_value(-32'd999999999);
      send_value(32'h8000_0000);

      configure(4'd1, 4'd2);
      send_value(32'd0);
      send_value(32'd9);
      send_value(32'd10);
      send_value(-32'd9);

      // out-of-range register values get clamped
      configure(4'd15, 4'd0);
      send_value(32'd123456789);
      send_value(-32'd1);
      send_value(32'h7FFF_FFFF);

      configure(4'd0, 4'd15);
      send_value(32'd7);
      send_value(-32'd3);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         configure(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         if (seg < SEGMENTS / 3) begin
            send_idle_pct = 6;
            recv_idle_pct = 58;
         end else if (seg < 2 * SEGMENTS / 3) begin
            send_idle_pct = 58;
            recv_idle_pct = 6;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (SEG_ITEMS) send_value(pick_value());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
         $display("fixed_point_decimal_formatter_core_tb passed");
      end else begin
         $display("fixed_point_decimal_formatter_core_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
